@@ rtl/zce_pkg.sv @@
// Package with the shared types and constants of the zero-crossing edge marker.
package zce_pkg;

    // Sign class of one filtered sample
    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_POS  = 2'd1,
        CLS_NEG  = 2'd2
    } cls_t;

    // Configuration register indexes
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Register widths and reset values
    localparam int FRAME_WIDTH_BITS  = 11;
    localparam int FRAME_HEIGHT_BITS = 13;
    localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Row limits
    localparam logic [FRAME_HEIGHT_BITS-1:0] MIN_HEIGHT = 13'd3;
    localparam logic [FRAME_HEIGHT_BITS-1:0] MAX_HEIGHT = 13'd4096;
    localparam int ROW_BITS = 12;

    // Per-pixel position flags handed down the pipeline
    typedef struct packed {
        logic interior;
        logic row_end;
        logic frame_end;
    } pos_flags_t;

endpackage

@@ rtl/zce_ifs.sv @@
// Stream and configuration interfaces of the zero-crossing edge marker.
interface zce_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface zce_mark_if;
    logic valid;
    logic ready;
    logic edge_res;
    logic row_end;
    logic frame_end;

    modport source (output valid, output edge_res, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input edge_res, input row_end, input frame_end,
                    output ready);
endinterface

interface zce_cfg_if;
    import zce_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/zce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module zce_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ rtl/zce_pos_ctrl.sv @@
// Column and row counters that place each request in the frame.
module zce_pos_ctrl
    import zce_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     eff_width,
    input  logic [FRAME_HEIGHT_BITS-1:0]       eff_height,
    output logic [$clog2(MAX_WIDTH)-1:0]       col,
    output pos_flags_t                         flags
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;

    logic                         col_wrap;
    logic [FRAME_HEIGHT_BITS-1:0] row_pre;
    logic [ROW_BITS-1:0]          row_cur;
    logic [CW-1:0]                col_cur;
    logic [WW-1:0]                col_inc;
    logic [FRAME_HEIGHT_BITS-1:0] row_inc;
    logic                         row_last;

    // Wrap counters that stand at or past a bound lowered by a register write
    always_comb
    begin
        col_wrap = (WW'(col_reg) >= eff_width);
        col_cur  = col_wrap ? '0 : col_reg;
        row_pre  = FRAME_HEIGHT_BITS'(row_reg) + (col_wrap ? 13'd1 : 13'd0);
        row_cur  = (row_pre >= eff_height) ? '0 : row_pre[ROW_BITS-1:0];
    end

    // Position flags and next counter values
    always_comb
    begin
        col_inc  = WW'(col_cur) + WW'(1);
        row_inc  = FRAME_HEIGHT_BITS'(row_cur) + 13'd1;
        row_last = (row_inc >= eff_height);

        flags.interior  = (row_cur >= ROW_BITS'(2)) && (col_cur >= CW'(2));
        flags.row_end   = (col_inc >= eff_width);
        flags.frame_end = flags.row_end && row_last;
        col             = col_cur;

        if (flags.row_end)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_inc[ROW_BITS-1:0];
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_cur;
        end
    end

    // Advance counters on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end
endmodule

@@ rtl/zce_window.sv @@
// Diagonal window of sign classes and the zero-crossing decision.
module zce_window
    import zce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic shift,
    input  cls_t top,
    input  cls_t cur,
    output logic edge_res
);
    // Upper and lower rows at columns c-1 and c-2
    cls_t up1_reg, low1_reg, up2_reg, low2_reg;
    cls_t diag [4];
    logic neg, pos;

    // Shift the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up1_reg  <= CLS_ZERO;
            low1_reg <= CLS_ZERO;
            up2_reg  <= CLS_ZERO;
            low2_reg <= CLS_ZERO;
        end
        else if (shift)
        begin
            up2_reg  <= up1_reg;
            low2_reg <= low1_reg;
            up1_reg  <= top;
            low1_reg <= cur;
        end
    end

    // Look for both a negative and a positive among the diagonal neighbors
    always_comb
    begin
        diag[0] = up2_reg;
        diag[1] = low2_reg;
        diag[2] = top;
        diag[3] = cur;
        neg = 1'b0;
        pos = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            case (diag[i])
                CLS_NEG: neg = 1'b1;
                CLS_POS: pos = 1'b1;
                default: ;
            endcase
        end
        edge_res = neg && pos;
    end
endmodule

@@ rtl/zero_crossing_edge_3x3.sv @@
// Top level of the 3x3 zero-crossing edge marker.
// Takes one signed filtered sample per clock in raster order while the result side
// keeps up, and gives one mark for every interior pixel of the frame (border rows and
// columns give none). The mark for a sample passes through stage one, with the
// registered read of the line-store RAM, and then the output register (one port
// read, one port written per cycle). Both line stores share one RAM of MAX_WIDTH
// entries holding two sign classes each. Width and height are clamped to 3..MAX_WIDTH
// and 3..4096; registers are to be written only when idle; the block does not check.
module zero_crossing_edge_3x3
    import zce_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    zce_sample_if.sink    samples,
    zce_mark_if.source    marks,
    zce_cfg_if.sink       cfg
);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > FRAME_WIDTH_BITS) ? WW : FRAME_WIDTH_BITS;

    logic [FRAME_WIDTH_BITS-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_BITS-1:0] frame_height_reg;
    logic [CMPW-1:0]              width_ext;
    logic [WW-1:0]                eff_width;
    logic [FRAME_HEIGHT_BITS-1:0] eff_height;

    logic       in_accept;
    logic [CW-1:0] pos_col;
    pos_flags_t pos_flags;
    cls_t       in_cls;

    logic          s1_valid_reg;
    cls_t          s1_cls_reg;
    logic [CW-1:0] s1_col_reg;
    pos_flags_t    s1_flags_reg;
    logic          s1_adv;

    logic [3:0] ram_rd_data;
    cls_t       top_cls, mid_cls;
    logic       edge_comb;

    logic out_valid_reg;
    logic edge_reg, row_end_reg, frame_end_reg;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data[FRAME_WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Clamp frame size to the supported range
    always_comb
    begin
        width_ext = CMPW'(frame_width_reg);
        if (width_ext < CMPW'(3))
        begin
            eff_width = WW'(3);
        end
        else if (width_ext > CMPW'(MAX_WIDTH))
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext[WW-1:0];
        end

        if (frame_height_reg < MIN_HEIGHT)
        begin
            eff_height = MIN_HEIGHT;
        end
        else if (frame_height_reg > MAX_HEIGHT)
        begin
            eff_height = MAX_HEIGHT;
        end
        else
        begin
            eff_height = frame_height_reg;
        end
    end

    // Accept a request whenever stage one is empty or moving on
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || marks.ready);
    assign samples.ready = !s1_valid_reg || s1_adv;
    assign in_accept     = samples.valid && samples.ready;

    // Reduce the sample to its sign class
    always_comb
    begin
        if (samples.sample == '0)
        begin
            in_cls = CLS_ZERO;
        end
        else if (samples.sample[SAMPLE_BITS-1])
        begin
            in_cls = CLS_NEG;
        end
        else
        begin
            in_cls = CLS_POS;
        end
    end

    zce_pos_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (in_accept),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .col        (pos_col),
        .flags      (pos_flags)
    );

    // Stage one: hold class and position while the line stores are read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cls_reg   <= in_cls;
            s1_col_reg   <= pos_col;
            s1_flags_reg <= pos_flags;
        end
    end

    // Line stores: upper class in the high pair, middle class in the low pair
    zce_ram #(
        .WIDTH (4),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_cls, s1_cls_reg}),
        .rd_en   (in_accept),
        .rd_addr (pos_col),
        .rd_data (ram_rd_data)
    );

    assign top_cls = cls_t'(ram_rd_data[3:2]);
    assign mid_cls = cls_t'(ram_rd_data[1:0]);

    zce_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (s1_adv),
        .top      (top_cls),
        .cur      (s1_cls_reg),
        .edge_res (edge_comb)
    );

    // Output register: load interior marks, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_flags_reg.interior;
        end
        else if (marks.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            edge_reg      <= edge_comb;
            row_end_reg   <= s1_flags_reg.row_end;
            frame_end_reg <= s1_flags_reg.frame_end;
        end
    end

    assign marks.valid     = out_valid_reg;
    assign marks.edge_res  = edge_reg;
    assign marks.row_end   = row_end_reg;
    assign marks.frame_end = frame_end_reg;
endmodule

@@ bench/zce_mark_checker.sv @@
// Checker that predicts every edge mark of the zero-crossing marker and compares it.
module zce_mark_checker
    import zce_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    zce_sample_if samples,
    zce_mark_if   marks,
    zce_cfg_if    cfg,
    output int    mismatches,
    output int    pending,
    output bit    frame_start,
    output int    line_len,
    output int    frame_rows,
    output int    frame_left
);

    typedef struct packed {
        logic edge_res;
        logic row_end;
        logic frame_end;
    } mark_t;

    // Marks still owed by the block, oldest first
    mark_t marks_due[$];

    // Own copy of the sign history and raster position
    cls_t upper_line [MAX_WIDTH];
    cls_t middle_line[MAX_WIDTH];
    cls_t win[6];
    int   col_pos;
    int   row_pos;
    int   mark_index;

    logic [FRAME_WIDTH_BITS-1:0]  width_reg;
    logic [FRAME_HEIGHT_BITS-1:0] height_reg;

    mark_t got_mark;
    mark_t want_mark;

    function automatic cls_t sign_class_of(input logic [SAMPLE_BITS-1:0] v);
        if (v == '0)
            return CLS_ZERO;
        if (v[SAMPLE_BITS-1])
            return CLS_NEG;
        return CLS_POS;
    endfunction

    function automatic int active_width();
        if (width_reg < 3)
            return 3;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int active_height();
        if (height_reg < MIN_HEIGHT)
            return int'(MIN_HEIGHT);
        if (height_reg > MAX_HEIGHT)
            return int'(MAX_HEIGHT);
        return int'(height_reg);
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    // Refresh the view of the raster position that the stimulus side steers by
    function automatic void publish();
        int w;
        int h;
        int c;
        int r;
        w = active_width();
        h = active_height();
        c = col_pos;
        r = row_pos;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h)
            r = 0;
        pending     = marks_due.size();
        frame_start = (col_pos == 0) && (row_pos == 0);
        line_len    = w;
        frame_rows  = h;
        frame_left  = (h - 1 - r) * w + (w - c);
    endfunction

    // Advance the raster by one sample request and queue the mark it owes, if any
    task automatic take_sample(input logic [SAMPLE_BITS-1:0] v);
        int    w;
        int    h;
        cls_t  s;
        cls_t  top_cls;
        cls_t  mid_cls;
        cls_t  diag[4];
        bit    neg;
        bit    pos;
        bit    rend;
        mark_t m;
        w = active_width();
        h = active_height();
        // Wrap counters left beyond a bound that shrank
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;

        s       = sign_class_of(v);
        top_cls = upper_line[col_pos];
        mid_cls = middle_line[col_pos];
        upper_line[col_pos]  = mid_cls;
        middle_line[col_pos] = s;

        // Interior pixel: look at the four diagonal neighbours only
        if (row_pos >= 2 && col_pos >= 2) begin
            diag = '{win[3], win[5], top_cls, s};
            neg  = 1'b0;
            pos  = 1'b0;
            foreach (diag[i]) begin
                if (diag[i] == CLS_NEG)
                    neg = 1'b1;
                else if (diag[i] == CLS_POS)
                    pos = 1'b1;
            end
            rend        = (col_pos + 1 >= w);
            m.edge_res  = neg && pos;
            m.row_end   = rend;
            m.frame_end = rend && (row_pos + 1 >= h);
            marks_due.insert(marks_due.size(), m);
        end

        // Shift the window one column
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = top_cls;
        win[1] = mid_cls;
        win[2] = s;

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            marks_due.delete();
            foreach (win[i])
                win[i] = CLS_ZERO;
            col_pos    = 0;
            row_pos    = 0;
            mark_index = 0;
            mismatches = 0;
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
        end else begin
            // Compare first: a mark never comes from the request taken at the same edge
            if (marks.valid && marks.ready) begin
                got_mark = '{marks.edge_res, marks.row_end, marks.frame_end};
                if (marks_due.size() == 0) begin
                    note_failure($sformatf(
                        "mark %0d not due: edge=%0b row_end=%0b frame_end=%0b",
                        mark_index, got_mark.edge_res, got_mark.row_end,
                        got_mark.frame_end));
                end else begin
                    want_mark = marks_due.pop_front();
                    if (got_mark !== want_mark)
                        note_failure($sformatf(
                            "mark %0d: expected e/r/f=%0b/%0b/%0b, got %0b/%0b/%0b",
                            mark_index, want_mark.edge_res, want_mark.row_end,
                            want_mark.frame_end, got_mark.edge_res, got_mark.row_end,
                            got_mark.frame_end));
                end
                mark_index++;
            end

            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_FRAME_WIDTH)
                    width_reg = cfg.data[FRAME_WIDTH_BITS-1:0];
                else if (cfg.index == REG_FRAME_HEIGHT)
                    height_reg = cfg.data[FRAME_HEIGHT_BITS-1:0];
            end

            if (samples.valid && samples.ready)
                take_sample(samples.sample);
        end
        publish();
    end

endmodule

@@ bench/tb.sv @@
// Stimulus, handshake pacing and verdict for the zero-crossing edge marker.
module tb;
    import zce_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int RANDOM_ITEMS  = 720;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_STALL    = 300;

    // Indexes that map to no register
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

    // Three 3x3 frames: mixed-sign diagonals, all-positive diagonals with a
    // negative ring, negative and zero diagonals around a positive center
    localparam logic signed [SAMPLE_BITS-1:0] DIRECTED_SAMPLES [27] = '{
        16'sh8000, 16'sh0000, 16'sh7fff,
        16'sh0000, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh0001,
        16'sh0001, 16'shffff, 16'sh0001,
        16'shffff, 16'sh0000, 16'shffff,
        16'sh0001, 16'shffff, 16'sh0001,
        16'shffff, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh7fff, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh8000
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    zce_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples();
    zce_mark_if                                marks();
    zce_cfg_if                                 cfg();

    int mismatches;
    int pending;
    bit frame_start;
    int line_len;
    int frame_rows;
    int frame_left;
    int cycles;
    bit long_stall_req;
    bit steady;
    int burst_left;

    zero_crossing_edge_3x3 #(
        .MAX_WIDTH  (MAX_WIDTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(samples),
        .marks  (marks),
        .cfg    (cfg)
    );

    zce_mark_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .marks      (marks),
        .cfg        (cfg),
        .mismatches (mismatches),
        .pending    (pending),
        .frame_start(frame_start),
        .line_len   (line_len),
        .frame_rows (frame_rows),
        .frame_left (frame_left)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[zero_crossing_edge_3x3] ERROR");
        $finish;
    end

    // Pace the mark side with a changing stall pattern, plus one long hold on request
    initial
    begin
        int mode;
        int span;
        marks.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(32, 200);
            repeat (span) begin
                @(negedge clk);
                if (long_stall_req) begin
                    marks.ready <= 1'b0;
                    repeat (LONG_STALL) @(negedge clk);
                    long_stall_req = 1'b0;
                end
                case (mode)
                    0:       marks.ready <= 1'b1;
                    1:       marks.ready <= 1'($urandom_range(0, 1));
                    2:       marks.ready <= ($urandom_range(0, 3) == 0);
                    default: marks.ready <= (cycles % 3 != 0);
                endcase
            end
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        int t;
        case ($urandom_range(0, 4))
            0: return '0;
            1: begin
                t = $urandom_range(1, 40);
                return SAMPLE_BITS'(t);
            end
            2: begin
                t = $urandom_range(1, 40);
                return SAMPLE_BITS'(-t);
            end
            3: return SAMPLE_BITS'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh0001;
                    default: return 16'shffff;
                endcase
            end
        endcase
    endfunction

    // Offer one sample request at a falling edge and hold it until taken
    task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] v);
        int gap;
        if (!steady && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            samples.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        samples.valid  <= 1'b1;
        samples.sample <= v;
        @(posedge clk);
        while (!samples.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            offer_sample(random_sample());
    endtask

    // Drop valid, wait for every owed mark, then let the pipeline drain
    task automatic settle();
        samples.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Caller lowers cfg.valid after the last write of a group
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0]  idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_BITS-1:0] wdata,
                             input logic [CFG_DATA_BITS-1:0] hdata);
        settle();
        write_reg(REG_FRAME_WIDTH, wdata);
        write_reg(REG_FRAME_HEIGHT, hdata);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int n;
        logic [CFG_DATA_BITS-1:0] wdata;
        logic [CFG_DATA_BITS-1:0] hdata;

        samples.valid  <= 1'b0;
        samples.sample <= '0;
        cfg.valid      <= 1'b0;
        cfg.index      <= REG_FRAME_WIDTH;
        cfg.data       <= '0;
        steady         = 1'b0;
        burst_left     = 0;
        long_stall_req = 1'b0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: smallest frame, sample extremes, spare indexes ignored
        write_reg(REG_SPARE_LO, CFG_DATA_BITS'($urandom));
        write_reg(REG_SPARE_HI, '1);
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        cfg.valid <= 1'b0;
        foreach (DIRECTED_SAMPLES[i])
            offer_sample(DIRECTED_SAMPLES[i]);

        // Width above range clamps to the store depth, height below range to 3;
        // then narrow the line mid-row so the column counter wraps to the next row
        set_frame(13'd2047, 13'd0);
        send_random(40);
        set_frame(13'd3, 13'd0);
        send_random(frame_left);

        // Width below range clamps to 3, height above range clamps; then shorten
        // the frame mid-way and finish it
        set_frame(13'd0, 13'h1fff);
        send_random(3 * 30);
        set_frame(13'd0, 13'd40);
        send_random(frame_left);

        // Hold the mark side off while samples keep coming, then pause until drained
        set_frame(13'd5, 13'd6);
        steady         = 1'b1;
        long_stall_req = 1'b1;
        send_random(5 * line_len * frame_rows);
        steady = 1'b0;

        // Random frames; a wider line only from the top of a frame
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 7))
                0:       wdata = CFG_DATA_BITS'($urandom_range(0, 2));
                1:       wdata = (CFG_DATA_BITS'($urandom_range(0, 3)) << FRAME_WIDTH_BITS)
                                 | CFG_DATA_BITS'($urandom_range(3, 16));
                default: wdata = CFG_DATA_BITS'($urandom_range(3, 16));
            endcase
            if (!frame_start && int'(wdata[FRAME_WIDTH_BITS-1:0]) > line_len)
                wdata = CFG_DATA_BITS'($urandom_range(0, line_len));
            case ($urandom_range(0, 7))
                0:       hdata = CFG_DATA_BITS'($urandom_range(0, 2));
                1:       hdata = CFG_DATA_BITS'($urandom_range(11, 8191));
                default: hdata = CFG_DATA_BITS'($urandom_range(3, 10));
            endcase
            set_frame(wdata, hdata);

            // Finish a frame only when little of it is left; add whole frames only if small
            if (frame_left > 200 || $urandom_range(0, 3) == 0)
                n = $urandom_range(1, 2 * line_len);
            else if (line_len * frame_rows > 200)
                n = frame_left;
            else
                n = frame_left + line_len * frame_rows * $urandom_range(0, 2);
            steady = ($urandom_range(0, 3) == 0);
            send_random(n);
            sent += n;
        end
        steady = 1'b0;

        settle();
        if (mismatches == 0)
            $display("[zero_crossing_edge_3x3] OK");
        else
            $display("[zero_crossing_edge_3x3] ERROR");
        $finish;
    end

endmodule
